>>> rtl/core/ubxnav_pkg.sv
// shared types and constants of the ubx nav frame parser
`timescale 1ns / 1ps
package ubxnav_pkg;

  // payload bytes at this offset or beyond are summed but not stored
  localparam int unsigned MaxPayload = 256;

  localparam logic [7:0] SyncOne  = 8'hB5;
  localparam logic [7:0] SyncTwo  = 8'h62;
  localparam logic [7:0] ClassNav = 8'h01;

  localparam logic [15:0] LenPosition = 16'd28;
  localparam logic [15:0] LenVelocity = 16'd36;
  localparam logic [15:0] LenStatus   = 16'd16;
  localparam logic [15:0] LenSolution = 16'd52;
  localparam logic [15:0] LenUtcTime  = 16'd20;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    StNone   = 2'd0,
    StError  = 2'd1,
    StAccept = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrSync1    = 3'd1,
    ErrSync2    = 3'd2,
    ErrChecksum = 3'd3,
    ErrClass    = 3'd4,
    ErrIdSize   = 3'd5
  } cause_e;

  typedef enum logic [2:0] {
    KindPosition = 3'd0,
    KindVelocity = 3'd1,
    KindStatus   = 3'd2,
    KindSatInfo  = 3'd3,
    KindSolution = 3'd4,
    KindUtcTime  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    RegIdPosition = 3'd0,
    RegIdVelocity = 3'd1,
    RegIdStatus   = 3'd2,
    RegIdSatInfo  = 3'd3,
    RegIdSolution = 3'd4,
    RegIdUtcTime  = 3'd5
  } reg_e;

  typedef struct packed {
    logic [7:0] id_position;
    logic [7:0] id_velocity;
    logic [7:0] id_status;
    logic [7:0] id_satellite_info;
    logic [7:0] id_solution;
    logic [7:0] id_utc_time;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    id_position:       8'd2,
    id_velocity:       8'd18,
    id_status:         8'd3,
    id_satellite_info: 8'd48,
    id_solution:       8'd6,
    id_utc_time:       8'd33
  };

  typedef struct packed {
    status_e    status;
    logic [7:0] accepted_id;
    cause_e     error_cause;
    logic       payload_valid;
    kind_e      payload_kind;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       commit;
    kind_e      commit_kind;
  } res_t;

endpackage

>>> rtl/core/ubxnav_cfg.sv
// apb register file holding the six nav message ids
`timescale 1ns / 1ps
module ubxnav_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ubxnav_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [ubxnav_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [ubxnav_pkg::CfgDataWidth-1:0]  prdata,
  output logic                                 pready,
  output ubxnav_pkg::cfg_t                     cfg_o
);
  import ubxnav_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  reg_e reg_idx;
  logic wr_en;
  logic [7:0] rd_val;

  assign reg_idx = reg_e'(paddr[CfgAddrWidth-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegIdPosition: cfg_d.id_position       = pwdata[7:0];
        RegIdVelocity: cfg_d.id_velocity       = pwdata[7:0];
        RegIdStatus:   cfg_d.id_status         = pwdata[7:0];
        RegIdSatInfo:  cfg_d.id_satellite_info = pwdata[7:0];
        RegIdSolution: cfg_d.id_solution       = pwdata[7:0];
        RegIdUtcTime:  cfg_d.id_utc_time       = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegIdPosition: rd_val = cfg_q.id_position;
      RegIdVelocity: rd_val = cfg_q.id_velocity;
      RegIdStatus:   rd_val = cfg_q.id_status;
      RegIdSatInfo:  rd_val = cfg_q.id_satellite_info;
      RegIdSolution: rd_val = cfg_q.id_solution;
      RegIdUtcTime:  rd_val = cfg_q.id_utc_time;
      default:       rd_val = 8'd0;
    endcase
  end

  assign prdata = {{(CfgDataWidth-8){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/ubxnav_parser.sv
// frame parser state and per-byte result logic
`timescale 1ns / 1ps
module ubxnav_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  ubxnav_pkg::cfg_t  cfg_i,
  output ubxnav_pkg::res_t  res_o
);
  import ubxnav_pkg::*;

  localparam logic [2:0] PhSync1 = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhClass = 3'd2;
  localparam logic [2:0] PhId    = 3'd3;
  localparam logic [2:0] PhLen   = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhCkA   = 3'd6;
  localparam logic [2:0] PhCkB   = 3'd7;

  localparam logic [15:0] MaxPayloadLen = 16'(MaxPayload);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic        len_sel_q, len_sel_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_a_q, ck_a_d;
  logic        skip_q, skip_d;
  kind_e       kind_q, kind_d;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        known;
  kind_e       new_kind;

  assign sum_a_add = sum_a_q + rx_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_full  = {rx_byte_i, len_q[7:0]};
  assign count_inc = count_q + 16'd1;

  // first matching id wins, in register order
  always_comb begin
    known    = 1'b1;
    new_kind = KindPosition;
    priority if (id_q == cfg_i.id_position && len_full == LenPosition) begin
      new_kind = KindPosition;
    end else if (id_q == cfg_i.id_velocity && len_full == LenVelocity) begin
      new_kind = KindVelocity;
    end else if (id_q == cfg_i.id_status && len_full == LenStatus) begin
      new_kind = KindStatus;
    end else if (id_q == cfg_i.id_satellite_info) begin
      new_kind = KindSatInfo;
    end else if (id_q == cfg_i.id_solution && len_full == LenSolution) begin
      new_kind = KindSolution;
    end else if (id_q == cfg_i.id_utc_time && len_full == LenUtcTime) begin
      new_kind = KindUtcTime;
    end else begin
      known = 1'b0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    class_d   = class_q;
    id_d      = id_q;
    len_d     = len_q;
    len_sel_d = len_sel_q;
    count_d   = count_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    ck_a_d    = ck_a_q;
    skip_d    = skip_q;
    kind_d    = kind_q;

    res_o               = '0;
    res_o.status        = StNone;
    res_o.error_cause   = ErrNone;
    res_o.payload_kind  = KindPosition;
    res_o.commit_kind   = KindPosition;

    unique case (phase_q)
      PhSync1: begin
        if (rx_byte_i == SyncOne) begin
          phase_d = PhSync2;
        end else begin
          res_o.status      = StError;
          res_o.error_cause = ErrSync1;
        end
      end
      PhSync2: begin
        // a repeated first sync byte keeps waiting for the second
        if (rx_byte_i == SyncTwo) begin
          sum_a_d = 8'd0;
          sum_b_d = 8'd0;
          phase_d = PhClass;
        end else if (rx_byte_i != SyncOne) begin
          res_o.status      = StError;
          res_o.error_cause = ErrSync2;
          phase_d           = PhSync1;
        end
      end
      PhClass: begin
        class_d = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhId;
      end
      PhId: begin
        id_d      = rx_byte_i;
        sum_a_d   = sum_a_add;
        sum_b_d   = sum_b_add;
        len_sel_d = 1'b0;
        len_d     = 16'd0;
        phase_d   = PhLen;
      end
      PhLen: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        if (!len_sel_q) begin
          len_d     = {len_q[15:8], rx_byte_i};
          len_sel_d = 1'b1;
        end else begin
          len_d     = len_full;
          len_sel_d = 1'b0;
          if (class_q == ClassNav) begin
            if (known) begin
              kind_d = new_kind;
              skip_d = 1'b0;
            end else begin
              // skipped quietly: cause only, no error status
              skip_d            = 1'b1;
              res_o.error_cause = ErrIdSize;
            end
          end else begin
            skip_d            = 1'b1;
            res_o.status      = StError;
            res_o.error_cause = ErrClass;
          end
          count_d = 16'd0;
          phase_d = (len_full == 16'd0) ? PhCkA : PhData;
        end
      end
      PhData: begin
        if (!skip_q) begin
          if (count_q < MaxPayloadLen) begin
            res_o.payload_valid = 1'b1;
            res_o.payload_kind  = kind_q;
            res_o.payload_index = count_q[7:0];
            res_o.payload_byte  = rx_byte_i;
          end
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
        count_d = count_inc;
        if (count_inc == len_q) begin
          phase_d = PhCkA;
        end
      end
      PhCkA: begin
        ck_a_d  = rx_byte_i;
        phase_d = PhCkB;
      end
      PhCkB: begin
        if (sum_a_q == ck_a_q && sum_b_q == rx_byte_i) begin
          if (!skip_q) begin
            res_o.status      = StAccept;
            res_o.accepted_id = id_q;
            res_o.commit      = 1'b1;
            res_o.commit_kind = kind_q;
          end
        end else begin
          res_o.status      = StError;
          res_o.error_cause = ErrChecksum;
        end
        phase_d = PhSync1;
      end
      default: phase_d = PhSync1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSync1;
      class_q   <= 8'd0;
      id_q      <= 8'd0;
      len_q     <= 16'd0;
      len_sel_q <= 1'b0;
      count_q   <= 16'd0;
      sum_a_q   <= 8'd0;
      sum_b_q   <= 8'd0;
      ck_a_q    <= 8'd0;
      skip_q    <= 1'b0;
      kind_q    <= KindPosition;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      class_q   <= class_d;
      id_q      <= id_d;
      len_q     <= len_d;
      len_sel_q <= len_sel_d;
      count_q   <= count_d;
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      ck_a_q    <= ck_a_d;
      skip_q    <= skip_d;
      kind_q    <= kind_d;
    end
  end

endmodule

>>> rtl/core/ubx_nav_frame_parser.sv
// UBX nav frame parser, one received byte per request, one result per byte.
// Each accepted byte updates the parser state and produces its result in the
// same cycle, which lands in a single output register; with out_ready_i held
// high a byte is taken every clock, and the result shows in the cycle after its
// request. The output register sets the throughput: while it holds a result that
// is not taken, in_ready_o stays low. Payload bytes of known nav messages come
// out with kind and offset; a frame with a good checksum is reported by commit
// and status. The message ids are APB registers at byte addresses 0, 4, 8, 12,
// 16 and 20.
`timescale 1ns / 1ps
module ubx_nav_frame_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [7:0]                           accepted_id_o,
  output logic [2:0]                           error_cause_o,
  output logic                                 payload_valid_o,
  output logic [2:0]                           payload_kind_o,
  output logic [7:0]                           payload_index_o,
  output logic [7:0]                           payload_byte_o,
  output logic                                 commit_o,
  output logic [2:0]                           commit_kind_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ubxnav_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [ubxnav_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [ubxnav_pkg::CfgDataWidth-1:0]  prdata,
  output logic                                 pready
);
  import ubxnav_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  ubxnav_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ubxnav_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_fire),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign accepted_id_o   = out_q.accepted_id;
  assign error_cause_o   = out_q.error_cause;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_kind_o  = out_q.payload_kind;
  assign payload_index_o = out_q.payload_index;
  assign payload_byte_o  = out_q.payload_byte;
  assign commit_o        = out_q.commit;
  assign commit_kind_o   = out_q.commit_kind;

  // every request leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("no result after accepted byte");

  // a result that is not taken blocks the input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input ready while result stalled");

  // a commit always reports an accepted message
  a_commit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && commit_o) |-> (status_o == StAccept && !payload_valid_o))
    else $error("commit without accept status");

  // a payload byte is never an error
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (status_o == StNone && error_cause_o == ErrNone))
    else $error("payload byte with error");

endmodule

>>> tb/ubx_nav_frame_monitor.sv
// monitor that predicts and checks every ubx nav parser result
`timescale 1ns / 1ps
module ubx_nav_frame_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          status_i,
  input  logic [7:0]                          accepted_id_i,
  input  logic [2:0]                          error_cause_i,
  input  logic                                payload_valid_i,
  input  logic [2:0]                          payload_kind_i,
  input  logic [7:0]                          payload_index_i,
  input  logic [7:0]                          payload_byte_i,
  input  logic                                commit_i,
  input  logic [2:0]                          commit_kind_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic                                pready_i,
  input  logic [ubxnav_pkg::CfgAddrWidth-1:0] paddr_i,
  input  logic [ubxnav_pkg::CfgDataWidth-1:0] pwdata_i,
  output int                                  mismatch_count_o,
  output int                                  open_results_o
);
  import ubxnav_pkg::*;

  typedef enum logic [2:0] {
    PhSync1, PhSync2, PhClass, PhId, PhLen, PhBody, PhCkA, PhCkB
  } phase_e;

  localparam int MaxReported = 10;

  cfg_t        ids;
  phase_e      phase_q;
  logic [7:0]  cls_q;
  logic [7:0]  id_q;
  logic [15:0] len_q;
  logic        len_hi_q;
  logic [15:0] count_q;
  logic [7:0]  sum_a_q;
  logic [7:0]  sum_b_q;
  logic [7:0]  rx_ck_a_q;
  logic        skip_q;
  kind_e       kind_q;
  res_t        parsed_q[$];

  function automatic void add_to_sum(input logic [7:0] b);
    sum_a_q = sum_a_q + b;
    sum_b_q = sum_b_q + sum_a_q;
  endfunction

  // first matching id wins, satellite info takes any length
  function automatic logic lookup_kind(output kind_e k);
    lookup_kind = 1'b1;
    if (id_q == ids.id_position && len_q == LenPosition) k = KindPosition;
    else if (id_q == ids.id_velocity && len_q == LenVelocity) k = KindVelocity;
    else if (id_q == ids.id_status && len_q == LenStatus) k = KindStatus;
    else if (id_q == ids.id_satellite_info) k = KindSatInfo;
    else if (id_q == ids.id_solution && len_q == LenSolution) k = KindSolution;
    else if (id_q == ids.id_utc_time && len_q == LenUtcTime) k = KindUtcTime;
    else begin
      k = KindPosition;
      lookup_kind = 1'b0;
    end
  endfunction

  function automatic res_t step_parser(input logic [7:0] b);
    res_t  r;
    kind_e k;
    r = '0;
    case (phase_q)
      PhSync1: begin
        if (b == SyncOne) begin
          phase_q = PhSync2;
        end else begin
          r.status = StError;
          r.error_cause = ErrSync1;
        end
      end
      PhSync2: begin
        if (b == SyncTwo) begin
          sum_a_q = '0;
          sum_b_q = '0;
          phase_q = PhClass;
        end else if (b != SyncOne) begin
          r.status = StError;
          r.error_cause = ErrSync2;
          phase_q = PhSync1;
        end
      end
      PhClass: begin
        cls_q = b;
        add_to_sum(b);
        phase_q = PhId;
      end
      PhId: begin
        id_q = b;
        add_to_sum(b);
        len_hi_q = 1'b0;
        len_q = '0;
        phase_q = PhLen;
      end
      PhLen: begin
        add_to_sum(b);
        if (!len_hi_q) begin
          len_q[7:0] = b;
          len_hi_q = 1'b1;
        end else begin
          len_q[15:8] = b;
          len_hi_q = 1'b0;
          if (cls_q != ClassNav) begin
            skip_q = 1'b1;
            r.status = StError;
            r.error_cause = ErrClass;
          end else if (lookup_kind(k)) begin
            kind_q = k;
            skip_q = 1'b0;
          end else begin
            // unknown id or size is flagged but not an error return
            skip_q = 1'b1;
            r.error_cause = ErrIdSize;
          end
          count_q = '0;
          phase_q = (len_q == '0) ? PhCkA : PhBody;
        end
      end
      PhBody: begin
        // skipped bodies are counted only, never summed
        if (!skip_q) begin
          if (count_q < MaxPayload) begin
            r.payload_valid = 1'b1;
            r.payload_kind = kind_q;
            r.payload_index = count_q[7:0];
            r.payload_byte = b;
          end
          add_to_sum(b);
        end
        count_q = count_q + 16'd1;
        if (count_q == len_q) phase_q = PhCkA;
      end
      PhCkA: begin
        rx_ck_a_q = b;
        phase_q = PhCkB;
      end
      default: begin
        if (sum_a_q == rx_ck_a_q && sum_b_q == b) begin
          if (!skip_q) begin
            r.status = StAccept;
            r.accepted_id = id_q;
            r.commit = 1'b1;
            r.commit_kind = kind_q;
          end
        end else begin
          r.status = StError;
          r.error_cause = ErrChecksum;
        end
        phase_q = PhSync1;
      end
    endcase
    return r;
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf({"status=%0d id=0x%02h cause=%0d payload(v=%0d kind=%0d idx=%0d ",
                      "byte=0x%02h) commit=%0d kind=%0d"},
                     r.status, r.accepted_id, r.error_cause, r.payload_valid,
                     r.payload_kind, r.payload_index, r.payload_byte, r.commit,
                     r.commit_kind);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      ids = CfgReset;
      phase_q = PhSync1;
      cls_q = '0;
      id_q = '0;
      len_q = '0;
      len_hi_q = 1'b0;
      count_q = '0;
      sum_a_q = '0;
      sum_b_q = '0;
      rx_ck_a_q = '0;
      skip_q = 1'b0;
      kind_q = KindPosition;
      parsed_q.delete();
      mismatch_count_o = 0;
      open_results_o = 0;
    end else begin
      // results leave before the request of this edge is parsed
      if (out_valid_i && out_ready_i) begin
        got = {status_i, accepted_id_i, error_cause_i, payload_valid_i, payload_kind_i,
               payload_index_i, payload_byte_i, commit_i, commit_kind_i};
        if (parsed_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MaxReported)
            $display("unexpected result: %s", describe(got));
        end else begin
          want = parsed_q.pop_front();
          if (got.status !== want.status || got.accepted_id !== want.accepted_id ||
              got.error_cause !== want.error_cause ||
              got.payload_valid !== want.payload_valid ||
              got.payload_kind !== want.payload_kind ||
              got.payload_index !== want.payload_index ||
              got.payload_byte !== want.payload_byte || got.commit !== want.commit ||
              got.commit_kind !== want.commit_kind) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MaxReported) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) parsed_q.push_back(step_parser(rx_byte_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[CfgAddrWidth-1:2]))
          RegIdPosition: ids.id_position       = pwdata_i[7:0];
          RegIdVelocity: ids.id_velocity       = pwdata_i[7:0];
          RegIdStatus:   ids.id_status         = pwdata_i[7:0];
          RegIdSatInfo:  ids.id_satellite_info = pwdata_i[7:0];
          RegIdSolution: ids.id_solution       = pwdata_i[7:0];
          RegIdUtcTime:  ids.id_utc_time       = pwdata_i[7:0];
          default: ;
        endcase
      end
      open_results_o = parsed_q.size();
    end
  end

endmodule

>>> tb/tb_ubx_nav_frame_parser.sv
// testbench top for the ubx nav frame parser: byte stream stimulus and verdict
`timescale 1ns / 1ps
module tb_ubx_nav_frame_parser;
  import ubxnav_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RxHoldCycles  = 80;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              rx_byte_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              status_o;
  logic [7:0]              accepted_id_o;
  logic [2:0]              error_cause_o;
  logic                    payload_valid_o;
  logic [2:0]              payload_kind_o;
  logic [7:0]              payload_index_o;
  logic [7:0]              payload_byte_o;
  logic                    commit_o;
  logic [2:0]              commit_kind_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  int          mismatch_count;
  int          open_results;
  int          idle_cycles;
  int unsigned bytes_sent;
  bit          no_gaps;
  bit          rx_hold_req;
  logic [7:0]  nav_ids [6];
  logic [7:0]  frame_ck_a;
  logic [7:0]  frame_ck_b;

  ubx_nav_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .accepted_id_o  (accepted_id_o),
    .error_cause_o  (error_cause_o),
    .payload_valid_o(payload_valid_o),
    .payload_kind_o (payload_kind_o),
    .payload_index_o(payload_index_o),
    .payload_byte_o (payload_byte_o),
    .commit_o       (commit_o),
    .commit_kind_o  (commit_kind_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ubx_nav_frame_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .accepted_id_i   (accepted_id_o),
    .error_cause_i   (error_cause_o),
    .payload_valid_i (payload_valid_o),
    .payload_kind_i  (payload_kind_o),
    .payload_index_i (payload_index_o),
    .payload_byte_i  (payload_byte_o),
    .commit_i        (commit_o),
    .commit_kind_i   (commit_kind_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .mismatch_count_o(mismatch_count),
    .open_results_o  (open_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_summed(input logic [7:0] b);
    frame_ck_a = frame_ck_a + b;
    frame_ck_b = frame_ck_b + frame_ck_a;
    send_byte(b);
  endtask

  // sum_body low gives the checksum a skipped frame needs to pass
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg_id,
                            input logic [15:0] len, input bit sum_body,
                            input bit dup_sync, input bit bad_ck);
    int          i;
    int unsigned pos;
    logic [7:0]  b;
    frame_ck_a = '0;
    frame_ck_b = '0;
    send_byte(SyncOne);
    if (dup_sync) send_byte(SyncOne);
    send_byte(SyncTwo);
    send_summed(cls);
    send_summed(msg_id);
    send_summed(len[7:0]);
    send_summed(len[15:8]);
    for (i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      if (sum_body) send_summed(b);
      else send_byte(b);
    end
    if (bad_ck) begin
      pos = $urandom_range(0, 7);
      if ($urandom_range(0, 1) != 0) frame_ck_a[pos] = ~frame_ck_a[pos];
      else frame_ck_b[pos] = ~frame_ck_b[pos];
    end
    send_byte(frame_ck_a);
    send_byte(frame_ck_b);
  endtask

  task automatic apb_write(input reg_e r, input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {24'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    nav_ids[r] = v;
  endtask

  task automatic set_ids(input logic [7:0] pos_id, input logic [7:0] vel_id,
                         input logic [7:0] stat_id, input logic [7:0] sat_id,
                         input logic [7:0] sol_id, input logic [7:0] utc_id);
    apb_write(RegIdPosition, pos_id);
    apb_write(RegIdVelocity, vel_id);
    apb_write(RegIdStatus, stat_id);
    apb_write(RegIdSatInfo, sat_id);
    apb_write(RegIdSolution, sol_id);
    apb_write(RegIdUtcTime, utc_id);
  endtask

  // sampled on the falling edge so the monitor has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (open_results != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] body_len(input kind_e k);
    case (k)
      KindPosition: body_len = LenPosition;
      KindVelocity: body_len = LenVelocity;
      KindStatus:   body_len = LenStatus;
      KindSolution: body_len = LenSolution;
      KindUtcTime:  body_len = LenUtcTime;
      default:      body_len = 16'($urandom_range(0, 24));
    endcase
  endfunction

  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    kind_e       k;
    logic [15:0] len;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    k = kind_e'($urandom_range(0, 5));
    len = body_len(k);
    if (pick < 55) begin
      send_frame(ClassNav, nav_ids[k], len, 1'b1, $urandom_range(0, 9) == 0, 1'b0);
    end else if (pick < 65) begin
      send_frame(ClassNav, nav_ids[k], len, 1'b1, 1'b0, 1'b1);
    end else if (pick < 75) begin
      // nav class with a foreign id or a size that does not fit
      b = ($urandom_range(0, 1) != 0) ? nav_ids[k] : 8'($urandom);
      send_frame(ClassNav, b, 16'($urandom_range(0, 12)), 1'($urandom), 1'b0, 1'b0);
    end else if (pick < 85) begin
      send_frame(ClassNav ^ 8'($urandom_range(1, 255)), 8'($urandom),
                 16'($urandom_range(0, 8)), 1'($urandom), 1'b0, 1'b0);
    end else if (pick < 93) begin
      // line noise never opens a frame
      n = $urandom_range(1, 3);
      repeat (n) begin
        b = 8'($urandom);
        if (b == SyncOne) b = ~b;
        send_byte(b);
      end
    end else begin
      send_byte(SyncOne);
      b = 8'($urandom);
      if (b == SyncOne || b == SyncTwo) b = '0;
      send_byte(b);
    end
  endtask

  task automatic random_stream(input int unsigned n, input bit with_pressure);
    int unsigned stop;
    bit          held;
    bit          paused;
    stop = bytes_sent + n;
    held = 1'b0;
    paused = 1'b0;
    while (bytes_sent < stop) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if (with_pressure && !held && bytes_sent + 2 * n / 3 > stop) begin
        rx_hold_req = 1'b1;
        held = 1'b1;
      end
      if (with_pressure && !paused && bytes_sent + n / 3 > stop) begin
        wait_drained();
        paused = 1'b1;
      end
      random_frame();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    nav_ids[KindPosition] = CfgReset.id_position;
    nav_ids[KindVelocity] = CfgReset.id_velocity;
    nav_ids[KindStatus]   = CfgReset.id_status;
    nav_ids[KindSatInfo]  = CfgReset.id_satellite_info;
    nav_ids[KindSolution] = CfgReset.id_solution;
    nav_ids[KindUtcTime]  = CfgReset.id_utc_time;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad first sync, repeated sync bytes, bad second sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncOne);
    send_byte(SyncOne);
    send_byte(SyncOne);
    send_byte(8'h00);
    // zero-length satellite info commits, zero-length foreign class is an error
    send_frame(ClassNav, nav_ids[KindSatInfo], '0, 1'b1, 1'b0, 1'b0);
    send_frame(8'h02, 8'h01, '0, 1'b0, 1'b0, 1'b0);
    wait_drained();

    random_stream(50, 1'b1);
    wait_drained();

    // duplicate ids, first match in the lookup order wins
    set_ids(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    random_stream(20, 1'b0);
    wait_drained();

    set_ids(8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A);
    random_stream(20, 1'b0);
    wait_drained();

    set_ids(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom));
    // satellite info longer than the buffer still commits
    send_frame(ClassNav, nav_ids[KindSatInfo], 16'd257, 1'b1, 1'b0, 1'b0);
    random_stream(20, 1'b0);
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
